FILE: rtl/dqne_pkg.sv
// ----------------------------------------------------------------------------
// DNS question name extractor package
// Shared result kinds and the result transaction type.
// ----------------------------------------------------------------------------
package dqne_pkg;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] HDR_FLAG_MASK = 8'hf8;
  localparam logic [7:0] CHAR_LOW      = 8'd33;
  localparam logic [7:0] CHAR_HIGH     = 8'd126;
  localparam logic [7:0] CHAR_DOT      = 8'h2e;
  localparam logic [7:0] CHAR_BSLASH   = 8'h5c;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_char;
    logic [15:0] query_type;
    logic [7:0]  name_length;
  } result_t;

endpackage

FILE: rtl/dns_question_name_extractor_top.sv
// ----------------------------------------------------------------------------
// DNS question name extractor
// Parses a DNS message byte stream and emits the first question's name.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless a held result stalls the input; set by
// the single parse step between the input register and the result register.
// Reset: synchronous, active low; parse state returns to the header phase.
// After the last byte of a message the state also returns to the header phase.
module dns_question_name_extractor_top #(
  parameter int MAX_NAME_CHARS  = 253,
  parameter int MAX_LABEL_CHARS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_name_char,
  output logic [15:0] out_query_type,
  output logic [7:0]  out_name_length
);
  import dqne_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       out_hold;
  logic       res_valid;
  result_t    res;
  result_t    out_data;

  // Advance the input register whenever the result register can take a result
  assign s1_go    = s1_valid_r && !out_hold;
  assign in_stall = s1_valid_r && out_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  dqne_parser #(
    .MAX_NAME_CHARS  (MAX_NAME_CHARS),
    .MAX_LABEL_CHARS (MAX_LABEL_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_go),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  dqne_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_go && res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .hold      (out_hold),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_result_kind = out_data.result_kind;
  assign out_name_char   = out_data.name_char;
  assign out_query_type  = out_data.query_type;
  assign out_name_length = out_data.name_length;

endmodule

FILE: rtl/dqne_parser.sv
// ----------------------------------------------------------------------------
// DNS question name extractor: parser step
// Holds the message walk state and computes the result of one byte.
// ----------------------------------------------------------------------------
module dqne_parser #(
  parameter int MAX_NAME_CHARS  = 253,
  parameter int MAX_LABEL_CHARS = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              res_valid,
  output dqne_pkg::result_t res
);
  import dqne_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_CHARS  = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [3:0] HDR_FLAGS   = 4'd2;
  localparam logic [3:0] HDR_CNT_HI  = 4'd4;
  localparam logic [3:0] HDR_CNT_LO  = 4'd5;
  localparam logic [3:0] HDR_LAST    = 4'd11;

  localparam logic [7:0] MAX_LABEL_B = 8'(MAX_LABEL_CHARS);
  localparam logic [9:0] MAX_NAME_W  = 10'(MAX_NAME_CHARS);

  logic [2:0] phase_r, phase_nxt;
  logic [3:0] hpos_r, hpos_nxt;
  logic       cnt_hi_r, cnt_hi_nxt;
  logic [5:0] lrem_r, lrem_nxt;
  logic       any_lbl_r, any_lbl_nxt;
  logic [7:0] elen_r, elen_nxt;
  logic [2:0] tpos_r, tpos_nxt;
  logic [7:0] type_hi_r, type_hi_nxt;
  logic [7:0] type_lo_r, type_lo_nxt;

  logic       is_char, is_accept, is_reject;
  logic [7:0] ch;
  logic [9:0] name_sum;
  logic [5:0] lrem_dec;

  assign name_sum = {2'b00, elen_r} + {2'b00, data_byte} + {9'd0, any_lbl_r};
  assign lrem_dec = lrem_r - 6'd1;

  always_comb begin
    phase_nxt   = phase_r;
    hpos_nxt    = hpos_r;
    cnt_hi_nxt  = cnt_hi_r;
    lrem_nxt    = lrem_r;
    any_lbl_nxt = any_lbl_r;
    elen_nxt    = elen_r;
    tpos_nxt    = tpos_r;
    type_hi_nxt = type_hi_r;
    type_lo_nxt = type_lo_r;
    is_char     = 1'b0;
    is_accept   = 1'b0;
    is_reject   = 1'b0;
    ch          = 8'd0;

    unique case (phase_r)
      PH_HEADER: begin
        if (hpos_r == HDR_FLAGS && (data_byte & HDR_FLAG_MASK) != 8'd0) begin
          is_reject = 1'b1;
        end else if (hpos_r == HDR_CNT_LO && !cnt_hi_r && data_byte == 8'd0) begin
          is_reject = 1'b1;
        end else begin
          if (hpos_r == HDR_CNT_HI) cnt_hi_nxt = (data_byte != 8'd0);
          if (hpos_r >= HDR_LAST) phase_nxt = PH_LENGTH;
          else                    hpos_nxt  = hpos_r + 4'd1;
        end
      end
      PH_LENGTH: begin
        if (data_byte == 8'd0) begin
          if (!any_lbl_r) begin
            is_reject = 1'b1;
          end else begin
            phase_nxt = PH_TAIL;
            tpos_nxt  = 3'd0;
          end
        end else if (data_byte > MAX_LABEL_B || name_sum > MAX_NAME_W) begin
          is_reject = 1'b1;
        end else begin
          if (any_lbl_r) begin
            is_char  = 1'b1;
            ch       = CHAR_DOT;
            elen_nxt = elen_r + 8'd1;
          end
          any_lbl_nxt = 1'b1;
          lrem_nxt    = data_byte[5:0];
          phase_nxt   = PH_CHARS;
        end
      end
      PH_CHARS: begin
        if (data_byte < CHAR_LOW || data_byte > CHAR_HIGH ||
            data_byte == CHAR_DOT || data_byte == CHAR_BSLASH) begin
          is_reject = 1'b1;
        end else begin
          is_char  = 1'b1;
          ch       = data_byte;
          elen_nxt = elen_r + 8'd1;
          lrem_nxt = lrem_dec;
          if (lrem_dec == 6'd0) phase_nxt = PH_LENGTH;
        end
      end
      PH_TAIL: begin
        if (tpos_r == 3'd0) type_hi_nxt = data_byte;
        if (tpos_r == 3'd1) type_lo_nxt = data_byte;
        if (tpos_r >= 3'd3) begin
          is_accept = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          tpos_nxt = tpos_r + 3'd1;
        end
      end
      default: ;
    endcase

    if (is_reject) phase_nxt = PH_DONE;

    // Early end of message turns anything short of a verdict into a reject
    if (last_byte) begin
      if (phase_r != PH_DONE && !is_accept && !is_reject) begin
        is_reject = 1'b1;
        is_char   = 1'b0;
        ch        = 8'd0;
      end
      phase_nxt   = PH_HEADER;
      hpos_nxt    = 4'd0;
      cnt_hi_nxt  = 1'b0;
      lrem_nxt    = 6'd0;
      any_lbl_nxt = 1'b0;
      elen_nxt    = 8'd0;
      tpos_nxt    = 3'd0;
      type_hi_nxt = 8'd0;
      type_lo_nxt = 8'd0;
    end
  end

  always_comb begin
    res_valid       = is_char || is_accept || is_reject;
    res.result_kind = is_accept ? KIND_ACCEPT : (is_reject ? KIND_REJECT : KIND_CHAR);
    res.name_char   = ch;
    res.query_type  = is_accept ? {type_hi_r, type_lo_r} : 16'd0;
    res.name_length = is_accept ? elen_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hpos_r    <= 4'd0;
      cnt_hi_r  <= 1'b0;
      lrem_r    <= 6'd0;
      any_lbl_r <= 1'b0;
      elen_r    <= 8'd0;
      tpos_r    <= 3'd0;
      type_hi_r <= 8'd0;
      type_lo_r <= 8'd0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hpos_r    <= hpos_nxt;
      cnt_hi_r  <= cnt_hi_nxt;
      lrem_r    <= lrem_nxt;
      any_lbl_r <= any_lbl_nxt;
      elen_r    <= elen_nxt;
      tpos_r    <= tpos_nxt;
      type_hi_r <= type_hi_nxt;
      type_lo_r <= type_lo_nxt;
    end
  end

endmodule

FILE: rtl/dqne_out_reg.sv
// ----------------------------------------------------------------------------
// DNS question name extractor: result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module dqne_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dqne_pkg::result_t load_data,
  input  logic              out_stall,
  output logic              hold,
  output logic              out_valid,
  output dqne_pkg::result_t out_data
);
  import dqne_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign hold      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

FILE: sim/dns_question_name_extractor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS question name extractor testbench
// Streams DNS messages byte by byte into the extractor. A scoreboard
// predicts every name character and each message's verdict and compares
// them with the result transactions. Most messages are well formed with random
// content. The rest carry header faults, bad labels, overlong names, early ends
// or plain noise. Both sides idle and stall at random save in the last stage.
// ----------------------------------------------------------------------------
module dns_question_name_extractor_top_tb;
  import dqne_pkg::*;

  localparam int MAX_NAME_CHARS  = 253;
  localparam int MAX_LABEL_CHARS = 63;
  localparam int LATENCY         = 2;
  localparam int TARGET_BYTES    = 1700;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 30;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_CHARS,
    PH_TAIL,
    PH_DONE
  } parse_phase_t;

  class question_scoreboard;
    result_t      expected_q[$];
    int           errors;
    parse_phase_t phase;
    logic [3:0]   hdr_pos;
    bit           qd_hi_nz;
    logic [5:0]   label_left;
    bit           label_seen;
    logic [7:0]   name_len;
    logic [2:0]   tail_pos;
    logic [7:0]   type_hi;
    logic [7:0]   type_lo;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase      = PH_HEADER;
      hdr_pos    = '0;
      qd_hi_nz   = 1'b0;
      label_left = '0;
      label_seen = 1'b0;
      name_len   = '0;
      tail_pos   = '0;
      type_hi    = '0;
      type_lo    = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("ERROR @%0t: %s", $time, what);
      end
    endtask

    // Advance the parse by one accepted byte and queue what it should produce.
    function void note_byte(logic [7:0] b, logic last);
      bit      was_done;
      bit      has;
      int      sep;
      result_t r;
      was_done = (phase == PH_DONE);
      has = 1'b0;
      r = '0;
      case (phase)
        PH_HEADER: begin
          if (hdr_pos == 2 && (b & HDR_FLAG_MASK) != 0) begin
            has = 1'b1;
            r.result_kind = KIND_REJECT;
          end else if (hdr_pos == 5 && !qd_hi_nz && b == 0) begin
            has = 1'b1;
            r.result_kind = KIND_REJECT;
          end else begin
            if (hdr_pos == 4) qd_hi_nz = (b != 0);
            if (hdr_pos >= 11) phase = PH_LENGTH;
            else hdr_pos = hdr_pos + 4'd1;
          end
        end
        PH_LENGTH: begin
          if (b == 0) begin
            if (!label_seen) begin
              has = 1'b1;
              r.result_kind = KIND_REJECT;
            end else begin
              phase = PH_TAIL;
              tail_pos = '0;
            end
          end else begin
            sep = label_seen ? 1 : 0;
            if (int'(b) > MAX_LABEL_CHARS || int'(name_len) + int'(b) + sep > MAX_NAME_CHARS)
            begin
              has = 1'b1;
              r.result_kind = KIND_REJECT;
            end else begin
              if (label_seen) begin
                has = 1'b1;
                r.result_kind = KIND_CHAR;
                r.name_char = CHAR_DOT;
                name_len = name_len + 8'd1;
              end
              label_seen = 1'b1;
              label_left = b[5:0];
              phase = PH_CHARS;
            end
          end
        end
        PH_CHARS: begin
          has = 1'b1;
          if (b < CHAR_LOW || b > CHAR_HIGH || b == CHAR_DOT || b == CHAR_BSLASH) begin
            r.result_kind = KIND_REJECT;
          end else begin
            r.result_kind = KIND_CHAR;
            r.name_char = b;
            name_len = name_len + 8'd1;
            label_left = label_left - 6'd1;
            if (label_left == 0) phase = PH_LENGTH;
          end
        end
        PH_TAIL: begin
          if (tail_pos == 0) type_hi = b;
          else if (tail_pos == 1) type_lo = b;
          if (tail_pos >= 3) begin
            has = 1'b1;
            r.result_kind = KIND_ACCEPT;
            r.query_type = {type_hi, type_lo};
            r.name_length = name_len;
            phase = PH_DONE;
          end else begin
            tail_pos = tail_pos + 3'd1;
          end
        end
        default: ;
      endcase
      if (has && r.result_kind == KIND_REJECT) phase = PH_DONE;
      // An open message that ends here yields only the reject.
      if (last) begin
        if (!was_done && !(has && r.result_kind != KIND_CHAR)) begin
          has = 1'b1;
          r = '0;
          r.result_kind = KIND_REJECT;
        end
        clear_parse();
      end
      if (has) expected_q.push_back(r);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d char %02h type %04h len %0d",
                         got.result_kind, got.name_char, got.query_type, got.name_length));
        return;
      end
      want = expected_q.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d, want %0d", got.result_kind, want.result_kind));
      if (got.name_char !== want.name_char)
        report($sformatf("name_char %02h, want %02h", got.name_char, want.name_char));
      if (got.query_type !== want.query_type)
        report($sformatf("query_type %04h, want %04h", got.query_type, want.query_type));
      if (got.name_length !== want.name_length)
        report($sformatf("name_length %0d, want %0d", got.name_length, want.name_length));
    endtask
  endclass

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_name_char;
  logic [15:0] out_query_type;
  logic [7:0]  out_name_length;

  question_scoreboard sb = new();
  logic [7:0] msg[$];
  int         bytes_sent     = 0;
  int         src_idle_pct   = 29;
  int         sink_stall_pct = 55;
  int         stuck_cycles   = 0;

  dns_question_name_extractor_top #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .MAX_LABEL_CHARS(MAX_LABEL_CHARS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_name_char  (out_name_char),
    .out_query_type (out_query_type),
    .out_name_length(out_name_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_result_kind, out_name_char, out_query_type, out_name_length});
    end
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // End the run once no transaction has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("dns_question_name_extractor_top_tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  // Hold the sender until every pending result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic void build_message();
    int         pick;
    int         shape;
    int         cut;
    bit         bad_chars;
    logic [7:0] c;
    int         lens[$];
    msg.delete();
    pick = $urandom_range(99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom));
      return;
    end
    repeat (12) msg.push_back(8'($urandom));
    if ($urandom_range(19) != 0) msg[2] = msg[2] & ~HDR_FLAG_MASK;
    case ($urandom_range(9))
      0: begin
        msg[4] = 8'h00;
        msg[5] = 8'h00;
      end
      1: begin
        msg[4] = 8'h00;
        msg[5] = 8'($urandom_range(1, 255));
      end
      2: begin
        msg[4] = 8'($urandom_range(1, 255));
        msg[5] = 8'h00;
      end
      default: if (msg[4] == 0 && msg[5] == 0) msg[5] = 8'h01;
    endcase
    shape = $urandom_range(19);
    if (shape == 1) begin
      lens = '{63, 63, 63, 61};  // exactly the longest legal name
    end else if (shape == 2) begin
      lens = '{63, 63, 63, 62};  // one character too long
    end else if (shape != 0) begin
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(9);
        lens.push_back(pick == 0 ? 63 : pick == 1 ? 1 : $urandom_range(1, 12));
      end
    end
    bad_chars = ($urandom_range(9) == 0);
    foreach (lens[i]) begin
      msg.push_back(8'(lens[i]));
      repeat (lens[i]) begin
        if (bad_chars && $urandom_range(15) == 0) begin
          case ($urandom_range(3))
            0: c = 8'($urandom_range(CHAR_LOW - 1, 0));
            1: c = 8'($urandom_range(255, CHAR_HIGH + 1));
            2: c = CHAR_DOT;
            default: c = CHAR_BSLASH;
          endcase
        end else begin
          do c = 8'($urandom_range(CHAR_HIGH, CHAR_LOW));
          while (c == CHAR_DOT || c == CHAR_BSLASH);
        end
        msg.push_back(c);
      end
    end
    if (lens.size() != 0 && $urandom_range(14) == 0) msg[12] = 8'($urandom_range(64, 255));
    msg.push_back(8'h00);
    repeat (4) msg.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, msg.size());
      msg = msg[0:cut-1];
    end
  endfunction

  initial begin
    int stage;
    stage = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Header flag fault, then a byte to ignore.
    msg = '{8'h12, 8'h34, 8'hf8, 8'h00};
    send_message();
    // Message that ends on its first byte.
    msg = '{8'hff};
    send_message();
    // One-character name "a", type ffff, one trailing byte.
    msg = '{8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h01, 8'h61, 8'h00, 8'hff, 8'hff, 8'h00, 8'h01, 8'haa};
    send_message();

    while (bytes_sent < TARGET_BYTES) begin
      if (stage == 0 && bytes_sent >= TARGET_BYTES / 3) begin
        drain_results();
        stage = 1;
        src_idle_pct = 55;
        sink_stall_pct = 29;
      end else if (stage == 1 && bytes_sent >= 2 * TARGET_BYTES / 3) begin
        drain_results();
        stage = 2;
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      build_message();
      send_message();
    end

    drain_results();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dns_question_name_extractor_top_tb passed");
    end else begin
      $display("dns_question_name_extractor_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dqne_pkg.sv
rtl/dqne_parser.sv
rtl/dqne_out_reg.sv
rtl/dns_question_name_extractor_top.sv
sim/dns_question_name_extractor_top_tb.sv
